@@ hdl/dmbm_pkg.sv @@
// Shared types and constants for the display mode best-match block.
`default_nettype none

package dmbm_pkg;

    localparam int unsigned HRES_W = 16;
    localparam int unsigned VRES_W = 16;
    localparam int unsigned DEPTH_W = 6;
    localparam int unsigned FLAGS_W = 5;
    localparam int unsigned MODE_W = 32;
    localparam int unsigned DMODE_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned FLAG_DEPTH_PRIO = 0;
    localparam int unsigned FLAG_ABSOLUTE = 1;
    localparam int unsigned FLAG_SHALLOW = 2;
    localparam int unsigned FLAG_MAXRES = 3;
    localparam int unsigned FLAG_ALLVALID = 4;

    localparam logic [FLAGS_W-1:0] FLAGS_RESET = 5'b00010;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQ_HORIZONTAL = 2'd0,
        CFG_REQ_VERTICAL   = 2'd1,
        CFG_REQ_DEPTH      = 2'd2,
        CFG_REQUEST_FLAGS  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [HRES_W-1:0]  horizontal;
        logic [VRES_W-1:0]  vertical;
        logic [DEPTH_W-1:0] depth;
        logic [FLAGS_W-1:0] flags;
    } request_t;

    typedef struct packed {
        logic [HRES_W-1:0]  horizontal;
        logic [VRES_W-1:0]  vertical;
        logic [DEPTH_W-1:0] depth;
        logic               timing_valid;
        logic               timing_safe;
    } cand_t;

    typedef struct packed {
        logic               have;
        logic [HRES_W-1:0]  horizontal;
        logic [VRES_W-1:0]  vertical;
        logic [DEPTH_W-1:0] depth;
        logic [MODE_W-1:0]  mode_data;
        logic [DMODE_W-1:0] depth_mode;
        logic               unsafe;
    } best_t;

endpackage

`default_nettype wire

@@ hdl/dmbm_judge.sv @@
// Eligibility and three-tier replacement decision for one candidate mode.
`default_nettype none

module dmbm_judge (
    input  var dmbm_pkg::request_t req,
    input  var dmbm_pkg::best_t    best,
    input  var dmbm_pkg::cand_t    cand,
    output logic                   take
);

    function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] r;
        begin
            r = (a >= b) ? (a - b) : (b - a);
            return r;
        end
    endfunction

    logic prio;
    logic absl;
    logic shal;
    logic maxr;
    logic allv;
    logic exact;
    logic abs_ok;
    logic res_ok;
    logic shallow_ok;
    logic raises;
    logic eligible;
    logic tier1;
    logic tier2;
    logic tier3;
    logic [15:0] dh_cand;
    logic [15:0] dh_best;
    logic [15:0] dv_cand;
    logic [15:0] dv_best;

    always_comb
    begin
        prio = req.flags[dmbm_pkg::FLAG_DEPTH_PRIO];
        absl = req.flags[dmbm_pkg::FLAG_ABSOLUTE];
        shal = req.flags[dmbm_pkg::FLAG_SHALLOW];
        maxr = req.flags[dmbm_pkg::FLAG_MAXRES];
        allv = req.flags[dmbm_pkg::FLAG_ALLVALID];

        exact = (cand.horizontal == req.horizontal) && (cand.vertical == req.vertical)
                && (cand.depth == req.depth);
        abs_ok = exact || !absl;
        res_ok = ((cand.horizontal >= req.horizontal) && (cand.vertical >= req.vertical))
                 || !maxr;
        shallow_ok = (cand.depth <= req.depth) || !shal;
        raises = (best.depth < req.depth) && (cand.depth > best.depth);

        dh_cand = absdiff16(req.horizontal, cand.horizontal);
        dh_best = absdiff16(req.horizontal, best.horizontal);
        dv_cand = absdiff16(req.vertical, cand.vertical);
        dv_best = absdiff16(req.vertical, best.vertical);

        tier1 = !best.have && res_ok && shallow_ok && abs_ok;
        tier2 = prio && (best.depth != req.depth)
                && (((cand.depth > best.depth) && (cand.depth <= req.depth)) || !shal)
                && raises && abs_ok;
        tier3 = (dh_cand <= dh_best) && (dv_cand <= dv_best) && res_ok
                && ((best.depth == cand.depth) || !prio) && shallow_ok
                && ((best.horizontal != cand.horizontal) || (best.vertical != cand.vertical)
                    || raises || (cand.depth == req.depth))
                && abs_ok;

        eligible = cand.timing_valid && (cand.timing_safe || allv);
        take = eligible && (tier1 || tier2 || tier3);
    end

endmodule

`default_nettype wire

@@ hdl/display_mode_best_match_top.sv @@
// Top level: input beat register, best-match decision, best-so-far state and result register.
// Path: an accepted input beat enters the input beat register, and its result beat is offered
//   from the result register. Throughput: one input beat per cycle while in_stall is low; the
//   best-so-far decision and update happen together, so candidates chain without bubbles.
// Reset: rst_n clears valid flags, request registers (flags to absolute) and the best-so-far
//   state; payload registers are not reset.
`default_nettype none

module display_mode_best_match_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] horizontal,
    input  logic [15:0] vertical,
    input  logic [5:0]  depth,
    input  logic        timing_valid,
    input  logic        timing_safe,
    input  logic [31:0] mode_data,
    input  logic [15:0] depth_switch_mode,
    input  logic        last_of_list,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic        taken,
    output logic [15:0] best_horizontal,
    output logic [15:0] best_vertical,
    output logic [5:0]  best_depth,
    output logic [31:0] best_mode_data,
    output logic [15:0] best_depth_mode,
    output logic        needs_confirmation,
    output logic        search_done
);

    dmbm_pkg::request_t req_reg;
    dmbm_pkg::best_t    best_reg;
    dmbm_pkg::best_t    best_next;
    dmbm_pkg::best_t    best_new;
    dmbm_pkg::cand_t    cand;

    logic        in_valid_reg;
    logic [15:0] in_h_reg;
    logic [15:0] in_v_reg;
    logic [5:0]  in_d_reg;
    logic        in_tv_reg;
    logic        in_ts_reg;
    logic [31:0] in_md_reg;
    logic [15:0] in_dm_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    dmbm_pkg::best_t out_best_reg;
    logic        out_taken_reg;
    logic        out_done_reg;

    logic        advance;
    logic        eval;
    logic        take;

    assign cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg.horizontal <= '0;
            req_reg.vertical   <= '0;
            req_reg.depth      <= '0;
            req_reg.flags      <= dmbm_pkg::FLAGS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dmbm_pkg::CFG_REQ_HORIZONTAL: req_reg.horizontal <= cfg_data;
                dmbm_pkg::CFG_REQ_VERTICAL:   req_reg.vertical <= cfg_data;
                dmbm_pkg::CFG_REQ_DEPTH:      req_reg.depth <= cfg_data[5:0];
                dmbm_pkg::CFG_REQUEST_FLAGS:  req_reg.flags <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign advance  = !out_valid_reg || !out_stall;
    assign eval     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_h_reg    <= horizontal;
            in_v_reg    <= vertical;
            in_d_reg    <= depth;
            in_tv_reg   <= timing_valid;
            in_ts_reg   <= timing_safe;
            in_md_reg   <= mode_data;
            in_dm_reg   <= depth_switch_mode;
            in_last_reg <= last_of_list;
        end
    end

    always_comb
    begin
        cand.horizontal   = in_h_reg;
        cand.vertical     = in_v_reg;
        cand.depth        = in_d_reg;
        cand.timing_valid = in_tv_reg;
        cand.timing_safe  = in_ts_reg;
    end

    dmbm_judge u_judge (
        .req  (req_reg),
        .best (best_reg),
        .cand (cand),
        .take (take)
    );

    always_comb
    begin
        best_new = best_reg;
        if (take)
        begin
            best_new.have       = 1'b1;
            best_new.horizontal = in_h_reg;
            best_new.vertical   = in_v_reg;
            best_new.depth      = in_d_reg;
            best_new.mode_data  = in_md_reg;
            best_new.depth_mode = in_dm_reg;
            best_new.unsafe     = !in_ts_reg;
        end
        best_next = best_reg;
        if (eval)
        begin
            best_next = in_last_reg ? '0 : best_new;
        end
    end

    // best-so-far state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            out_best_reg  <= best_new;
            out_taken_reg <= take;
            out_done_reg  <= in_last_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign found              = out_best_reg.have;
    assign taken              = out_taken_reg;
    assign best_horizontal    = out_best_reg.horizontal;
    assign best_vertical      = out_best_reg.vertical;
    assign best_depth         = out_best_reg.depth;
    assign best_mode_data     = out_best_reg.mode_data;
    assign best_depth_mode    = out_best_reg.depth_mode;
    assign needs_confirmation = out_best_reg.unsafe;
    assign search_done        = out_done_reg;

    a_taken_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!taken || found))
        else $error("taken beat without a chosen mode");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (best_horizontal == '0 && best_vertical == '0
            && best_depth == '0 && best_mode_data == '0 && best_depth_mode == '0
            && !needs_confirmation))
        else $error("best fields non-zero with no chosen mode");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (eval && in_last_reg) |=> (best_reg == '0))
        else $error("state not cleared after last beat of a list");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_best_reg)))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

@@ tb/display_mode_best_match_checker.sv @@
// Checker for the display mode best-match block: predicts every result beat and compares it.
module display_mode_best_match_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] horizontal,
    input  logic [15:0] vertical,
    input  logic [5:0]  depth,
    input  logic        timing_valid,
    input  logic        timing_safe,
    input  logic [31:0] mode_data,
    input  logic [15:0] depth_switch_mode,
    input  logic        last_of_list,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        found,
    input  logic        taken,
    input  logic [15:0] best_horizontal,
    input  logic [15:0] best_vertical,
    input  logic [5:0]  best_depth,
    input  logic [31:0] best_mode_data,
    input  logic [15:0] best_depth_mode,
    input  logic        needs_confirmation,
    input  logic        search_done,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          takes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [dmbm_pkg::HRES_W-1:0]  horizontal;
        logic [dmbm_pkg::VRES_W-1:0]  vertical;
        logic [dmbm_pkg::DEPTH_W-1:0] depth;
        logic                         timing_valid;
        logic                         timing_safe;
        logic [dmbm_pkg::MODE_W-1:0]  mode_data;
        logic [dmbm_pkg::DMODE_W-1:0] depth_switch_mode;
        logic                         last_of_list;
    } candidate_t;

    typedef struct packed {
        logic                         found;
        logic                         taken;
        logic [dmbm_pkg::HRES_W-1:0]  best_horizontal;
        logic [dmbm_pkg::VRES_W-1:0]  best_vertical;
        logic [dmbm_pkg::DEPTH_W-1:0] best_depth;
        logic [dmbm_pkg::MODE_W-1:0]  best_mode_data;
        logic [dmbm_pkg::DMODE_W-1:0] best_depth_mode;
        logic                         needs_confirmation;
        logic                         search_done;
    } match_report_t;

    dmbm_pkg::request_t request;
    dmbm_pkg::best_t    best;
    match_report_t      awaited_reports[$];
    match_report_t      seen_report;
    match_report_t      due_report;

    function automatic logic [15:0] span(logic [15:0] a, logic [15:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic beats_best(candidate_t c);
        logic prio;
        logic absl;
        logic shal;
        logic maxr;
        logic exact;
        logic abs_ok;
        logic res_ok;
        logic shallow_ok;
        logic raises;
        prio = request.flags[dmbm_pkg::FLAG_DEPTH_PRIO];
        absl = request.flags[dmbm_pkg::FLAG_ABSOLUTE];
        shal = request.flags[dmbm_pkg::FLAG_SHALLOW];
        maxr = request.flags[dmbm_pkg::FLAG_MAXRES];
        exact = c.horizontal == request.horizontal && c.vertical == request.vertical
                && c.depth == request.depth;
        abs_ok = exact || !absl;
        res_ok = (c.horizontal >= request.horizontal && c.vertical >= request.vertical)
                 || !maxr;
        shallow_ok = c.depth <= request.depth || !shal;
        raises = best.depth < request.depth && c.depth > best.depth;
        if (!best.have && res_ok && shallow_ok && abs_ok)
            return 1'b1;
        if (prio && best.depth != request.depth
            && ((c.depth > best.depth && c.depth <= request.depth) || !shal)
            && raises && abs_ok)
            return 1'b1;
        return span(request.horizontal, c.horizontal) <= span(request.horizontal, best.horizontal)
            && span(request.vertical, c.vertical) <= span(request.vertical, best.vertical)
            && res_ok
            && (best.depth == c.depth || !prio)
            && shallow_ok
            && (best.horizontal != c.horizontal || best.vertical != c.vertical || raises
                || c.depth == request.depth)
            && abs_ok;
    endfunction

    function automatic match_report_t rank_candidate(candidate_t c);
        logic          eligible;
        logic          take;
        match_report_t r;
        eligible = c.timing_valid
                   && (c.timing_safe || request.flags[dmbm_pkg::FLAG_ALLVALID]);
        take = eligible && beats_best(c);
        if (take)
        begin
            best.have = 1'b1;
            best.horizontal = c.horizontal;
            best.vertical = c.vertical;
            best.depth = c.depth;
            best.mode_data = c.mode_data;
            best.depth_mode = c.depth_switch_mode;
            best.unsafe = !c.timing_safe;
            takes_seen++;
        end
        r.found = best.have;
        r.taken = take;
        r.best_horizontal = best.horizontal;
        r.best_vertical = best.vertical;
        r.best_depth = best.depth;
        r.best_mode_data = best.mode_data;
        r.best_depth_mode = best.depth_mode;
        r.needs_confirmation = best.unsafe;
        r.search_done = c.last_of_list;
        if (c.last_of_list)
            best = '0;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_count < MAX_PRINTED)
            $display("MISMATCH at %0t, result beat %0d: %s", $realtime, results_seen, msg);
        fail_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            request = '0;
            request.flags = dmbm_pkg::FLAGS_RESET;
            best = '0;
            awaited_reports.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dmbm_pkg::CFG_REQ_HORIZONTAL: request.horizontal = cfg_data;
                    dmbm_pkg::CFG_REQ_VERTICAL:   request.vertical = cfg_data;
                    dmbm_pkg::CFG_REQ_DEPTH:
                        request.depth = cfg_data[dmbm_pkg::DEPTH_W-1:0];
                    dmbm_pkg::CFG_REQUEST_FLAGS:
                        request.flags = cfg_data[dmbm_pkg::FLAGS_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen_report = {found, taken, best_horizontal, best_vertical, best_depth,
                               best_mode_data, best_depth_mode, needs_confirmation, search_done};
                if (awaited_reports.size() == 0)
                    report_mismatch("result beat with nothing outstanding");
                else
                begin
                    due_report = awaited_reports.pop_front();
                    compare_field("found", 32'(seen_report.found), 32'(due_report.found));
                    compare_field("taken", 32'(seen_report.taken), 32'(due_report.taken));
                    compare_field("best_horizontal", 32'(seen_report.best_horizontal),
                                  32'(due_report.best_horizontal));
                    compare_field("best_vertical", 32'(seen_report.best_vertical),
                                  32'(due_report.best_vertical));
                    compare_field("best_depth", 32'(seen_report.best_depth),
                                  32'(due_report.best_depth));
                    compare_field("best_mode_data", seen_report.best_mode_data,
                                  due_report.best_mode_data);
                    compare_field("best_depth_mode", 32'(seen_report.best_depth_mode),
                                  32'(due_report.best_depth_mode));
                    compare_field("needs_confirmation", 32'(seen_report.needs_confirmation),
                                  32'(due_report.needs_confirmation));
                    compare_field("search_done", 32'(seen_report.search_done),
                                  32'(due_report.search_done));
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
                awaited_reports.push_back(rank_candidate({horizontal, vertical, depth,
                    timing_valid, timing_safe, mode_data, depth_switch_mode, last_of_list}));
        end
        pending <= awaited_reports.size();
    end

endmodule

@@ tb/display_mode_best_match_top_test.sv @@
// Testbench top for the display mode best-match block: clock, reset, stimulus and verdict.
module display_mode_best_match_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESULT_LATENCY = 1;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 630;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] horizontal;
    logic [15:0] vertical;
    logic [5:0]  depth;
    logic        timing_valid;
    logic        timing_safe;
    logic [31:0] mode_data;
    logic [15:0] depth_switch_mode;
    logic        last_of_list;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic        taken;
    logic [15:0] best_horizontal;
    logic [15:0] best_vertical;
    logic [5:0]  best_depth;
    logic [31:0] best_mode_data;
    logic [15:0] best_depth_mode;
    logic        needs_confirmation;
    logic        search_done;

    int fail_count;
    int pending;
    int results_seen;
    int takes_seen;

    int   idle_pct;
    int   stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_served = 1'b0;
    int   hold_cnt = 0;

    int          items_sent;
    int          lists_sent;
    int          request_settings;
    logic [15:0] want_h;
    logic [15:0] want_v;
    logic [5:0]  want_d;

    display_mode_best_match_top i_dut (.*);

    display_mode_best_match_checker i_checker (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_req && !hold_served)
        begin
            out_stall <= 1'b1;
            if (hold_cnt == HOLD_CYCLES - 1)
            begin
                hold_served <= 1'b1;
                hold_cnt <= 0;
            end
            else
                hold_cnt <= hold_cnt + 1;
        end
        else
        begin
            if (!hold_req)
                hold_served <= 1'b0;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic offer_mode(logic [15:0] h, logic [15:0] v, logic [5:0] d, logic tv,
                              logic ts, logic [31:0] md, logic [15:0] dm, logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        horizontal <= h;
        vertical <= v;
        depth <= d;
        timing_valid <= tv;
        timing_safe <= ts;
        mode_data <= md;
        depth_switch_mode <= dm;
        last_of_list <= last;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (last)
            lists_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic cfg_beat(dmbm_pkg::cfg_index_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_request(logic [15:0] h, logic [15:0] v, logic [15:0] d,
                               logic [15:0] flags);
        cfg_beat(dmbm_pkg::CFG_REQ_HORIZONTAL, h);
        cfg_beat(dmbm_pkg::CFG_REQ_VERTICAL, v);
        cfg_beat(dmbm_pkg::CFG_REQ_DEPTH, d);
        cfg_beat(dmbm_pkg::CFG_REQUEST_FLAGS, flags);
        cfg_valid <= 1'b0;
        want_h = h;
        want_v = v;
        want_d = d[5:0];
        request_settings++;
    endtask

    function automatic logic [15:0] common_extent();
        case ($urandom_range(0, 5))
            0: return 16'd480;
            1: return 16'd640;
            2: return 16'd768;
            3: return 16'd1024;
            4: return 16'd1280;
            default: return 16'd1920;
        endcase
    endfunction

    function automatic logic [15:0] near_extent(logic [15:0] base);
        case ($urandom_range(0, 7))
            0, 1, 2: return base;
            3: return base + 16'($urandom_range(1, 64));
            4: return base - 16'($urandom_range(1, 64));
            5: return common_extent();
            6: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] near_depth(logic [5:0] base);
        case ($urandom_range(0, 7))
            0, 1: return base;
            2: return base + 6'd1;
            3: return base - 6'd1;
            4: return 6'($urandom_range(1, 4) * 8);
            5: return 6'($urandom_range(0, 32));
            6: return 6'($urandom_range(0, 63));
            default: return 6'($urandom_range(0, 1) * 32);
        endcase
    endfunction

    task automatic random_request();
        logic [15:0] h;
        logic [15:0] v;
        logic [5:0]  d;
        logic [4:0]  f;
        case ($urandom_range(0, 5))
            0: h = 16'h0000;
            1: h = 16'hFFFF;
            2, 3: h = common_extent();
            default: h = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2, 3: v = common_extent();
            default: v = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: d = 6'd0;
            1: d = 6'd32;
            2: d = 6'd63;
            default: d = 6'($urandom_range(1, 4) * 8);
        endcase
        case ($urandom_range(0, 7))
            0: f = 5'h00;
            1: f = 5'h1F;
            default: f = 5'($urandom_range(0, 31));
        endcase
        set_request(h, v, {10'($urandom), d}, {11'($urandom), f});
    endtask

    task automatic random_list(int len, logic may_pause);
        for (int i = 0; i < len; i++)
        begin
            if (may_pause && $urandom_range(0, 99) < 2)
                settle();
            offer_mode(near_extent(want_h), near_extent(want_v), near_depth(want_d),
                       $urandom_range(0, 9) != 0, $urandom_range(0, 9) < 7,
                       $urandom_range(0, 7) == 0 ? 32'h0 : 32'($urandom),
                       16'($urandom), i == len - 1);
        end
    endtask

    task automatic run_phase(int send_idle, int recv_stall);
        int stop_at;
        int lists_left;
        stop_at = items_sent + PHASE_ITEMS;
        idle_pct = send_idle;
        stall_pct <= recv_stall;
        lists_left = 0;
        while (items_sent < stop_at)
        begin
            if (lists_left == 0)
            begin
                settle();
                random_request();
                lists_left = $urandom_range(3, 10);
            end
            random_list($urandom_range(0, 9) == 0 ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12), 1'b1);
            lists_left--;
        end
    endtask

    initial
    begin
        #1_000_000;
        $display("Timed out with %0d result beats outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = dmbm_pkg::CFG_REQ_HORIZONTAL;
        cfg_data = '0;
        in_valid = 1'b0;
        horizontal = '0;
        vertical = '0;
        depth = '0;
        timing_valid = 1'b0;
        timing_safe = 1'b0;
        mode_data = '0;
        depth_switch_mode = '0;
        last_of_list = 1'b0;
        want_h = '0;
        want_v = '0;
        want_d = '0;
        idle_pct = 15;
        stall_pct <= 82;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_mode(16'd0, 16'd0, 6'd0, 1'b1, 1'b1, 32'h0, 16'h0, 1'b0);
        offer_mode(16'hFFFF, 16'hFFFF, 6'h3F, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        settle();
        set_request(16'd640, 16'd480, 16'd16, 16'd0);
        offer_mode(16'd800, 16'd600, 6'd24, 1'b0, 1'b1, 32'h11, 16'h1, 1'b0);
        offer_mode(16'd800, 16'd600, 6'd24, 1'b1, 1'b0, 32'h12, 16'h2, 1'b0);
        offer_mode(16'd1024, 16'd768, 6'd32, 1'b1, 1'b1, 32'h13, 16'h3, 1'b0);
        offer_mode(16'd640, 16'd480, 6'd16, 1'b1, 1'b1, 32'h14, 16'h4, 1'b0);
        offer_mode(16'd640, 16'd480, 6'd16, 1'b1, 1'b1, 32'h15, 16'h5, 1'b1);
        settle();
        set_request(16'd640, 16'd480, 16'd16, 16'h1F);
        offer_mode(16'd640, 16'd480, 6'd16, 1'b1, 1'b0, 32'h21, 16'h6, 1'b0);
        offer_mode(16'd640, 16'd480, 6'd8, 1'b1, 1'b1, 32'h22, 16'h7, 1'b0);
        offer_mode(16'd640, 16'd480, 6'd16, 1'b1, 1'b1, 32'h23, 16'h8, 1'b1);
        settle();
        set_request(16'd1024, 16'd768, 16'd32, 16'(1 << dmbm_pkg::FLAG_DEPTH_PRIO));
        offer_mode(16'd800, 16'd600, 6'd8, 1'b1, 1'b1, 32'h31, 16'h9, 1'b0);
        offer_mode(16'd640, 16'd480, 6'd16, 1'b1, 1'b1, 32'h32, 16'hA, 1'b0);
        offer_mode(16'd1024, 16'd768, 6'd24, 1'b1, 1'b1, 32'h33, 16'hB, 1'b0);
        offer_mode(16'd1024, 16'd768, 6'd32, 1'b1, 1'b1, 32'h34, 16'hC, 1'b0);
        offer_mode(16'd1280, 16'd1024, 6'd40, 1'b1, 1'b1, 32'h35, 16'hD, 1'b0);
        offer_mode(16'd1024, 16'd768, 6'd32, 1'b1, 1'b1, 32'h36, 16'hE, 1'b1);
        settle();
        set_request(16'd1024, 16'd768, 16'd24,
                    16'((1 << dmbm_pkg::FLAG_MAXRES) | (1 << dmbm_pkg::FLAG_SHALLOW)));
        offer_mode(16'd800, 16'd600, 6'd16, 1'b1, 1'b1, 32'h41, 16'hF, 1'b0);
        offer_mode(16'd1280, 16'd1024, 6'd32, 1'b1, 1'b1, 32'h42, 16'h10, 1'b0);
        offer_mode(16'd1280, 16'd800, 6'd24, 1'b1, 1'b1, 32'h43, 16'h11, 1'b0);
        offer_mode(16'd1024, 16'd768, 6'd16, 1'b1, 1'b0, 32'h44, 16'h12, 1'b1);
        settle();
        set_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'(1 << dmbm_pkg::FLAG_ALLVALID));
        offer_mode(16'hFFFF, 16'hFFFF, 6'h3F, 1'b1, 1'b0, 32'h51, 16'h13, 1'b0);
        offer_mode(16'd0, 16'd0, 6'd0, 1'b1, 1'b1, 32'h52, 16'h14, 1'b1);

        run_phase(15, 82);
        run_phase(82, 15);

        settle();
        idle_pct = 0;
        stall_pct <= 0;
        random_request();
        hold_req <= 1'b1;
        random_list(40, 1'b0);
        in_valid <= 1'b0;
        do @(posedge clk); while (!hold_served);
        hold_req <= 1'b0;
        run_phase(0, 0);

        settle();
        repeat (10) @(posedge clk);
        $display("Run covered %0d candidates in %0d lists over %0d request settings,",
                 items_sent, lists_sent, request_settings);
        $display("  three idling mixes and a %0d-cycle output hold; %0d beats checked, %0d taken.",
                 HOLD_CYCLES, results_seen, takes_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/dmbm_pkg.sv
hdl/dmbm_judge.sv
hdl/display_mode_best_match_top.sv
tb/display_mode_best_match_checker.sv
tb/display_mode_best_match_top_test.sv
